[hw/rtl/fpmu_pkg.sv]
// package for the fixed-point math unit
// shared opcodes, controller/datapath command and status types, widths
// no dependencies
package fpmu_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int FIELD_W           = 32;
   localparam int CMD_W             = 4;
   localparam int REQ_DATA_W        = 104;
   localparam int RSP_DATA_W        = 40;
   localparam int DIV_W             = 64;
   localparam int DIV_CNT_W         = 6;
   localparam int SQRT_MAX_ITER     = 64;
   localparam int ITER_W            = 7;

   localparam logic [CMD_W-1:0] OP_MUL     = 4'd0;
   localparam logic [CMD_W-1:0] OP_FASTMUL = 4'd1;
   localparam logic [CMD_W-1:0] OP_DIV     = 4'd2;
   localparam logic [CMD_W-1:0] OP_RCP     = 4'd3;
   localparam logic [CMD_W-1:0] OP_MIN     = 4'd4;
   localparam logic [CMD_W-1:0] OP_MAX     = 4'd5;
   localparam logic [CMD_W-1:0] OP_MIN3    = 4'd6;
   localparam logic [CMD_W-1:0] OP_MAX3    = 4'd7;
   localparam logic [CMD_W-1:0] OP_CLAMP   = 4'd8;
   localparam logic [CMD_W-1:0] OP_FLOOR   = 4'd9;
   localparam logic [CMD_W-1:0] OP_SQRT    = 4'd10;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_MUL, ST_DIV_INIT, ST_DIV, ST_SQ_UPD,
      ST_SQ_LO, ST_SQ_HI, ST_SQ_CHECK, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      DP_NOP, DP_LOAD, DP_MUL, DP_DIV_INIT, DP_DIV_STEP, DP_SQ_UPD, DP_SQ_LO, DP_SQ_HI
   } dp_op_type;

   typedef enum logic [1:0] {
      CLS_SIMPLE, CLS_MUL, CLS_DIV, CLS_SQRT
   } cls_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_write;
   } dp_cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    den_zero;
      logic    sqrt_trivial;
      logic    div_last;
      logic    sqrt_more;
      logic    out_free;
   } dp_status_type;

endpackage

[hw/rtl/fixed_point_math_unit.sv]
// top level of the fixed-point math unit
// joins fpmu_ctrl and fpmu_dp; uses fpmu_pkg
//
// channel  direction  contents
// req      in         command, operand_a, operand_b, operand_c
// rsp      out        result, divide_by_zero
//
// one transaction at a time; div and rcp produce one quotient bit per cycle,
// and sqrt runs up to 64 newton rounds in the shared divider
// the result register frees the controller; a stalled rsp holds the next result
// synchronous active-high reset clears controller state and rsp_tvalid
module fixed_point_math_unit import fpmu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // command[3:0], operand_a[35:4], operand_b[67:36], operand_c[99:68], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result[31:0], divide_by_zero[32], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   fpmu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fpmu_dp #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_command (req_tdata[CMD_W-1:0]),
      .in_a       (req_tdata[CMD_W+FIELD_W-1:CMD_W]),
      .in_b       (req_tdata[CMD_W+2*FIELD_W-1:CMD_W+FIELD_W]),
      .in_c       (req_tdata[CMD_W+3*FIELD_W-1:CMD_W+2*FIELD_W]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hw/rtl/fpmu_ctrl.sv]
// controller state machine of the fixed-point math unit
// sequences load, multiply, divide and square-root steps; uses fpmu_pkg
module fpmu_ctrl import fpmu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (status.cls)
               CLS_SIMPLE: state_in = ST_FINISH;
               CLS_MUL:    state_in = ST_MUL;
               CLS_DIV:    state_in = status.den_zero ? ST_FINISH : ST_DIV_INIT;
               CLS_SQRT:   state_in = status.sqrt_trivial ? ST_FINISH : ST_DIV_INIT;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_MUL:      state_in = ST_FINISH;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) state_in = (status.cls == CLS_SQRT) ? ST_SQ_UPD : ST_FINISH;
         end
         ST_SQ_UPD:   state_in = ST_SQ_LO;
         ST_SQ_LO:    state_in = ST_SQ_HI;
         ST_SQ_HI:    state_in = ST_SQ_CHECK;
         ST_SQ_CHECK: state_in = status.sqrt_more ? ST_DIV_INIT : ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op        = DP_NOP;
      cmd.out_write = 1'b0;
      req_tready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = DP_LOAD;
         end
         ST_MUL:      cmd.op = DP_MUL;
         ST_DIV_INIT: cmd.op = DP_DIV_INIT;
         ST_DIV:      cmd.op = DP_DIV_STEP;
         ST_SQ_UPD:   cmd.op = DP_SQ_UPD;
         ST_SQ_LO:    cmd.op = DP_SQ_LO;
         ST_SQ_HI:    cmd.op = DP_SQ_HI;
         ST_FINISH:   cmd.out_write = status.out_free;
         default:     cmd.op = DP_NOP;
      endcase
   end

endmodule

[hw/rtl/fpmu_dp.sv]
// datapath of the fixed-point math unit
// operand registers, shared multiplier, radix-2 divider, newton update, output register
// uses fpmu_pkg
module fpmu_dp import fpmu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CMD_W-1:0]      in_command,
   input  logic [FIELD_W-1:0]    in_a,
   input  logic [FIELD_W-1:0]    in_b,
   input  logic [FIELD_W-1:0]    in_c,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int XS   = FIELD_W - WORD_BITS;
   localparam int HALF = FRAC_BITS / 2;

   function automatic logic signed [FIELD_W-1:0] wrap_w(input logic [FIELD_W-1:0] v);
      logic signed [FIELD_W-1:0] t;
      t = $signed(v << XS);
      return t >>> XS;
   endfunction

   logic [CMD_W-1:0]          op_ff;
   logic signed [FIELD_W-1:0] a_ff, b_ff, c_ff;
   logic [DIV_W-1:0]          prod_ff, prod_in;
   logic [DIV_W-1:0]          sq_ff;
   logic [DIV_W-1:0]          quo_ff, quo_in;
   logic [DIV_W:0]            rem_ff, rem_in;
   logic [DIV_W-1:0]          dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0]      cnt_ff;
   logic                      neg_ff, neg_in;
   logic [DIV_W-1:0]          x_ff, x_in;
   logic [ITER_W-1:0]         iter_ff;
   logic                      rsp_valid_ff;
   logic [FIELD_W-1:0]        res_ff;
   logic                      dz_ff;

   logic signed [FIELD_W:0]   mul_x, mul_y;
   logic signed [2*FIELD_W+1:0] mul_p;
   logic [DIV_W-1:0]          v64, num64, den64, n_sh, x_half;
   logic [DIV_W:0]            rem_sh;
   logic [DIV_W-1:0]          q_fix, qs_sh, x_upd, sq_full;
   logic signed [FIELD_W-1:0] mn2, mx2, res_comb;
   logic signed [FIELD_W-1:0] a_new;
   logic                      den_zero;

   // sign-extended first operand and its half as newton start
   assign v64    = {{(DIV_W-FIELD_W){a_ff[FIELD_W-1]}}, a_ff};
   assign x_half = {1'b0, v64[DIV_W-1:1]};
   assign a_new  = wrap_w(in_a);

   // shared multiplier
   always_comb begin
      unique case (cmd.op)
         DP_SQ_LO: begin
            mul_x = $signed({1'b0, x_ff[FIELD_W-1:0]});
            mul_y = $signed({1'b0, x_ff[FIELD_W-1:0]});
         end
         DP_SQ_HI: begin
            mul_x = $signed({1'b0, x_ff[DIV_W-1:FIELD_W]});
            mul_y = $signed({1'b0, x_ff[FIELD_W-1:0]});
         end
         default: begin
            if (op_ff == OP_FASTMUL) begin
               mul_x = $signed({a_ff[FIELD_W-1], a_ff}) >>> HALF;
               mul_y = $signed({b_ff[FIELD_W-1], b_ff}) >>> HALF;
            end else begin
               mul_x = $signed({a_ff[FIELD_W-1], a_ff});
               mul_y = $signed({b_ff[FIELD_W-1], b_ff});
            end
         end
      endcase
      mul_p = mul_x * mul_y;
   end

   // divider operand selection
   always_comb begin
      num64 = v64;
      den64 = {{(DIV_W-FIELD_W){b_ff[FIELD_W-1]}}, b_ff};
      if (op_ff == OP_RCP) begin
         num64 = DIV_W'(1) << FRAC_BITS;
         den64 = v64;
      end else if (op_ff == OP_SQRT) begin
         den64 = x_ff;
      end
   end
   assign n_sh     = num64 << (2 * FRAC_BITS);
   assign den_zero = (op_ff == OP_RCP) ? (a_ff == '0) : (b_ff == '0);
   assign rem_sh   = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      x_in    = x_ff;
      unique case (cmd.op) inside
         DP_LOAD: x_in = {1'b0, {(DIV_W-FIELD_W){a_new[FIELD_W-1]}}, a_new[FIELD_W-1:1]};
         DP_MUL, DP_SQ_LO, DP_SQ_HI: prod_in = mul_p[DIV_W-1:0];
         DP_DIV_INIT: begin
            rem_in = '0;
            if (op_ff == OP_SQRT) begin
               neg_in = 1'b0;
               quo_in = n_sh;
               dvs_in = den64;
            end else begin
               neg_in = n_sh[DIV_W-1] ^ den64[DIV_W-1];
               quo_in = n_sh[DIV_W-1] ? (DIV_W'(0) - n_sh) : n_sh;
               dvs_in = den64[DIV_W-1] ? (DIV_W'(0) - den64) : den64;
            end
         end
         DP_DIV_STEP: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh - {1'b0, dvs_ff};
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
         end
         DP_SQ_UPD: x_in = x_upd;
         default: x_in = x_ff;
      endcase
   end

   // newton update: a = q >> F; x = ((x + a) << 2F) / (2 << F) >> F
   always_comb begin
      logic [DIV_W-1:0] s;
      s     = (x_ff + (quo_ff >> FRAC_BITS)) << (2 * FRAC_BITS);
      x_upd = s >> (2 * FRAC_BITS + 1);
   end
   assign sq_full = sq_ff + (prod_ff << (FIELD_W + 1));

   assign q_fix = neg_ff ? (DIV_W'(0) - quo_ff) : quo_ff;
   assign qs_sh = DIV_W'($signed(q_fix) >>> FRAC_BITS);

   assign mn2 = (a_ff < b_ff) ? a_ff : b_ff;
   assign mx2 = (a_ff > b_ff) ? a_ff : b_ff;

   always_comb begin
      logic [DIV_W-1:0] pm;
      pm = DIV_W'($signed(prod_ff) >>> FRAC_BITS);
      case (op_ff) inside
         OP_MUL:          res_comb = wrap_w(pm[FIELD_W-1:0]);
         OP_FASTMUL:      res_comb = wrap_w(prod_ff[FIELD_W-1:0]);
         OP_DIV, OP_RCP:  res_comb = den_zero ? '0 : wrap_w(qs_sh[FIELD_W-1:0]);
         OP_MIN:          res_comb = mn2;
         OP_MAX:          res_comb = mx2;
         OP_MIN3:         res_comb = (mn2 < c_ff) ? mn2 : c_ff;
         OP_MAX3:         res_comb = (mx2 > c_ff) ? mx2 : c_ff;
         OP_CLAMP:        res_comb = (mx2 < c_ff) ? mx2 : c_ff;
         OP_FLOOR:        res_comb = wrap_w(a_ff & ~((FIELD_W'(1) << FRAC_BITS) - FIELD_W'(1)));
         OP_SQRT:         res_comb = status.sqrt_trivial ? '0 : wrap_w(x_ff[FIELD_W-1:0]);
         default:         res_comb = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      x_ff    <= x_in;
      if (cmd.op == DP_LOAD) begin
         op_ff   <= in_command;
         a_ff    <= a_new;
         b_ff    <= wrap_w(in_b);
         c_ff    <= wrap_w(in_c);
         iter_ff <= '0;
      end
      if (cmd.op == DP_SQ_UPD) iter_ff <= iter_ff + ITER_W'(1);
      if (cmd.op == DP_SQ_LO) sq_ff <= mul_p[DIV_W-1:0];
      if (cmd.op == DP_DIV_INIT) cnt_ff <= '0;
      else if (cmd.op == DP_DIV_STEP) cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      if (cmd.out_write) begin
         res_ff <= res_comb;
         dz_ff  <= (op_ff == OP_DIV) && den_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.cls = CLS_SIMPLE;
      unique case (op_ff) inside
         OP_MUL, OP_FASTMUL: status.cls = CLS_MUL;
         OP_DIV, OP_RCP:     status.cls = CLS_DIV;
         OP_SQRT:            status.cls = CLS_SQRT;
         default:            status.cls = CLS_SIMPLE;
      endcase
   end
   assign status.den_zero     = den_zero;
   assign status.sqrt_trivial = a_ff[FIELD_W-1] || (x_half == '0);
   assign status.div_last     = (cnt_ff == {DIV_CNT_W{1'b1}});
   assign status.sqrt_more    = (sq_full > (v64 << FRAC_BITS)) &&
                                (iter_ff != ITER_W'(SQRT_MAX_ITER));
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-FIELD_W-1){1'b0}}, dz_ff, res_ff};

endmodule

[tb/tb.sv]
// testbench for fixed_point_math_unit: streams commands, predicts each result
// in a behavioral fixed-point model and compares every response transaction
// depends on fpmu_pkg and the fixed_point_math_unit rtl
module tb import fpmu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [CMD_W-1:0] command;
      logic [31:0]      operand_a;
      logic [31:0]      operand_b;
      logic [31:0]      operand_c;
      bit               drain;
   } math_req_type;

   typedef struct {
      logic [31:0] result;
      logic        div_zero;
   } math_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   math_req_type pending_q[$];
   math_rsp_type answer_q[$];
   int        offered_cnt;
   int        accepted_cnt;
   int        returned_cnt;
   int        hold_cnt;
   bit        hold_done;
   int        error_cnt;
   bit        fill_done;

   fixed_point_math_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // q16.16 divide with a 64-bit left-shifted dividend, truncating quotient
   function automatic logic [31:0] fixed_quotient(logic [31:0] num, logic [31:0] den);
      logic [63:0] n, d, mn, md, q;
      longint      qs;
      n  = {{32{num[31]}}, num} << 32;
      d  = {{32{den[31]}}, den};
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q  = mn / md;
      if (n[63] ^ d[63]) q = -q;
      qs = $signed(q);
      qs = qs >>> 16;
      return qs[31:0];
   endfunction

   function automatic logic [31:0] fixed_sqrt(logic [31:0] val);
      logic [63:0] v, x, a, two;
      if ($signed(val) <= 0) return 32'd0;
      v = {32'd0, val};
      x = v >> 1;
      if (x == 0) return 32'd0;
      two = 64'd2 << 16;
      for (int n = 0; n < 64; n++) begin
         if (x == 0) break;
         a = ((v << 32) / x) >> 16;
         x = (((x + a) << 32) / two) >> 16;
         if (!(x * x > (v << 16))) break;
      end
      return x[31:0];
   endfunction

   function automatic logic [31:0] smin(logic [31:0] p, logic [31:0] q);
      return ($signed(p) < $signed(q)) ? p : q;
   endfunction

   function automatic logic [31:0] smax(logic [31:0] p, logic [31:0] q);
      return ($signed(p) > $signed(q)) ? p : q;
   endfunction

   function automatic math_rsp_type compute_math(math_req_type t);
      math_rsp_type r;
      longint    p;
      r.result   = 32'd0;
      r.div_zero = 1'b0;
      case (t.command)
         OP_MUL: begin
            p = longint'($signed(t.operand_a)) * longint'($signed(t.operand_b));
            p = p >>> 16;
            r.result = p[31:0];
         end
         OP_FASTMUL: begin
            p = longint'($signed(t.operand_a) >>> 8) * longint'($signed(t.operand_b) >>> 8);
            r.result = p[31:0];
         end
         OP_DIV: begin
            if (t.operand_b == 0) r.div_zero = 1'b1;
            else r.result = fixed_quotient(t.operand_a, t.operand_b);
         end
         OP_RCP:   if (t.operand_a != 0) r.result = fixed_quotient(32'h0001_0000, t.operand_a);
         OP_MIN:   r.result = smin(t.operand_a, t.operand_b);
         OP_MAX:   r.result = smax(t.operand_a, t.operand_b);
         OP_MIN3:  r.result = smin(smin(t.operand_a, t.operand_b), t.operand_c);
         OP_MAX3:  r.result = smax(smax(t.operand_a, t.operand_b), t.operand_c);
         OP_CLAMP: r.result = smin(smax(t.operand_a, t.operand_b), t.operand_c);
         OP_FLOOR: r.result = t.operand_a & 32'hFFFF_0000;
         OP_SQRT:  r.result = fixed_sqrt(t.operand_a);
         default:  r.result = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         6: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               3: return 32'h0000_0001;
               default: return 32'd0;
            endcase
         end
         7:       return ($urandom_range(0, 200) - 100) << 16;
         8:       return $urandom_range(0, 6) - 3;
         default: return $signed($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   task automatic queue_item(logic [CMD_W-1:0] cmd, logic [31:0] a, logic [31:0] b,
                             logic [31:0] c, bit drain = 1'b0);
      math_req_type t;
      t.command = cmd; t.operand_a = a; t.operand_b = b; t.operand_c = c; t.drain = drain;
      pending_q.push_back(t);
   endtask

   initial begin
      logic [CMD_W-1:0] cmd;
      reset = 1'b1;
      fill_done = 1'b0;
      queue_item(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      queue_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
      queue_item(OP_FASTMUL, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      queue_item(OP_FASTMUL, 32'h0001_8000, 32'hFFFE_0000, 0);
      queue_item(OP_DIV, 32'h0003_0000, 32'd0, 0);
      queue_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
      queue_item(OP_DIV, 32'hFFFD_0000, 32'h0002_0000, 0);
      queue_item(OP_RCP, 32'd0, 0, 0);
      queue_item(OP_RCP, 32'h8000_0000, 0, 0);
      queue_item(OP_RCP, 32'h0000_0001, 0, 0);
      queue_item(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      queue_item(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      queue_item(OP_MIN3, 32'h5, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_item(OP_MAX3, 32'h5, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      queue_item(OP_CLAMP, 32'h0010_0000, 32'h0002_0000, 32'h0001_0000);
      queue_item(OP_CLAMP, 32'hFFFF_0000, 32'h0000_0000, 32'h0005_0000);
      queue_item(OP_FLOOR, 32'hFFFF_8000, 0, 0);
      queue_item(OP_SQRT, 32'd0, 0, 0);
      queue_item(OP_SQRT, 32'd1, 0, 0);
      queue_item(OP_SQRT, 32'd2, 0, 0);
      queue_item(OP_SQRT, 32'h8000_0000, 0, 0);
      queue_item(OP_SQRT, 32'h7FFF_FFFF, 0, 0);
      queue_item(OP_SQRT, 32'h0004_0000, 0, 0);
      queue_item(4'd11, 32'h1234_5678, 32'h1, 32'h2);
      queue_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 1300; i++) begin
         cmd = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(11, 15)) :
                                           CMD_W'($urandom_range(0, 10));
         if ($urandom_range(9) == 0) cmd = OP_DIV;
         queue_item(cmd, pick_operand(), pick_operand(), pick_operand(), i == 700);
      end
      fill_done = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_q.size() == 0 && accepted_cnt == offered_cnt);
      wait (answer_q.size() == 0);
      repeat (200) @(posedge clock);
      if (error_cnt == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      #500ms;
      $display("tb: done, errors");
      $finish;
   end

   // driver: offers the next pending transaction once the previous one is taken
   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
   end

   always @(negedge clock) begin
      math_req_type t;
      bit        quiet;
      if (!reset && !(req_tvalid && accepted_cnt != offered_cnt)) begin
         quiet = offered_cnt >= 400 && offered_cnt < 600;
         if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= 7) &&
             (!pending_q[0].drain || (answer_q.size() == 0 && !rsp_tvalid))) begin
            t = pending_q.pop_front();
            req_tdata  <= {4'd0, t.operand_c, t.operand_b, t.operand_a, t.command};
            req_tvalid <= 1'b1;
            offered_cnt <= offered_cnt + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt   <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && returned_cnt == 300) begin
         hold_done  <= 1'b1;
         hold_cnt   <= 500;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (returned_cnt >= 800 && returned_cnt < 1000) || $urandom_range(99) >= 7;
      end
   end

   // monitor: predict on request accept, compare on response accept
   always @(posedge clock) begin
      math_req_type t;
      math_rsp_type exp_r;
      if (!reset && req_tvalid && req_tready) begin
         t.command   = req_tdata[3:0];
         t.operand_a = req_tdata[35:4];
         t.operand_b = req_tdata[67:36];
         t.operand_c = req_tdata[99:68];
         t.drain     = 1'b0;
         answer_q.push_back(compute_math(t));
         accepted_cnt <= accepted_cnt + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         returned_cnt <= returned_cnt + 1;
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected transaction, actual result %h dz %b",
                     $time, rsp_tdata[31:0], rsp_tdata[32]);
            error_cnt++;
         end else begin
            exp_r = answer_q.pop_front();
            if (rsp_tdata[31:0] !== exp_r.result) begin
               $display("%0t: result mismatch, expected %h actual %h",
                        $time, exp_r.result, rsp_tdata[31:0]);
               error_cnt++;
            end
            if (rsp_tdata[32] !== exp_r.div_zero) begin
               $display("%0t: divide_by_zero mismatch, expected %b actual %b",
                        $time, exp_r.div_zero, rsp_tdata[32]);
               error_cnt++;
            end
         end
      end
   end

endmodule
